// ===== rtl/lswc_pkg.sv =====
// Shared types, constants and helpers for the LRU sector write cache.
package lswc_pkg;

    localparam int SECTORS_PER_LINE = 8;
    localparam int SEC_W            = SECTORS_PER_LINE;
    localparam int OFF_W            = 3;
    localparam int ADDR_W           = 32;
    localparam int LEN_W            = 4;
    localparam int PAGE_W           = 29;
    localparam int SLOT_W           = 6;
    localparam int CACHE_LINES_DEF  = 64;
    localparam int IN_DATA_W        = 40;
    localparam int OUT_DATA_W       = 56;

    localparam logic [SEC_W-1:0] FULL_MASK = {SEC_W{1'b1}};

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        CMD_WRITE_STORAGE  = 3'd0,
        CMD_UPDATE_STORAGE = 3'd1,
        CMD_WRITE_DRAM     = 3'd2,
        CMD_READ_STORAGE   = 3'd3,
        CMD_READ_DRAM      = 3'd4,
        CMD_READ_BOTH      = 3'd5
    } cmd_t;

    typedef struct packed
    {
        cmd_t              command;
        logic [PAGE_W-1:0] page_address;
        logic [SEC_W-1:0]  storage_bitmap;
        logic              slot_valid;
        logic [SLOT_W-1:0] slot_id;
        logic [SEC_W-1:0]  cached_bitmap;
        logic              last;
    } result_t;

    // Sectors covered from offset for len positions, clipped at the line end.
    function automatic logic [SEC_W-1:0] range_mask(
        input logic [OFF_W-1:0] offset,
        input logic [LEN_W-1:0] len
    );
        logic [SEC_W-1:0] m;
        logic [LEN_W:0]   stop;
        m    = '0;
        stop = {2'b00, offset} + {1'b0, len};
        for (int p = 0; p < SEC_W; p++)
        begin
            m[p] = (OFF_W'(p) >= offset) && ((LEN_W+1)'(p) < stop);
        end
        return m;
    endfunction

endpackage

// ===== rtl/lswc_line_ram.sv =====
// Line store: one write port and one registered read port.
module lswc_line_ram
    import lswc_pkg::*;
#(
    parameter int DEPTH = CACHE_LINES_DEF,
    parameter int WIDTH = PAGE_W + SEC_W + 6
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lru_sector_write_cache.sv =====
// Top level of the fully associative LRU sector write cache.
// One request is taken at a time. Every line in use is swept once through the single
// read port of the line store to find a hit and the least recent line; a write then
// sweeps the lines in use a second time to age their ranks, one line per cycle. The
// number of lines in use is at most CACHE_LINES, and a request also waits on the
// output handshakes before the next one is taken.
// Slots fill from zero upwards and are never freed, so a fill count stands for the in-use
// flags and no clearing pass follows reset. A write miss on a full cache gives two words:
// the eviction, then the DRAM write.
module lru_sector_write_cache
    import lswc_pkg::*;
#(
    parameter int CACHE_LINES = CACHE_LINES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sector_address, length, zero pad
    input  logic                  s_axis_tuser,   // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // page_address, storage_bitmap,
                                                  // slot_valid, slot_id, cached_bitmap, pad
    output logic [2:0]            m_axis_tuser,   // command
    output logic                  m_axis_tlast
);

    localparam int IW = $clog2(CACHE_LINES);
    localparam int UW = $clog2(CACHE_LINES + 1);
    localparam int RW = IW;
    localparam int EW = PAGE_W + SEC_W + RW;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_TOUCH,
        ST_COMMIT,
        ST_EMIT1,
        ST_EMIT2
    } state_t;

    state_t            state_reg;
    op_t               op_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [SEC_W-1:0]  rng_reg;
    logic [UW-1:0]     idx_reg;
    logic [UW-1:0]     used_reg;
    logic              pend_reg;
    logic [IW-1:0]     pend_idx_reg;
    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic [SEC_W-1:0]  hit_sec_reg;
    logic [RW-1:0]     hit_rank_reg;
    logic [IW-1:0]     lru_idx_reg;
    logic [RW-1:0]     lru_rank_reg;
    logic [PAGE_W-1:0] lru_page_reg;
    logic [SEC_W-1:0]  lru_sec_reg;
    logic [IW-1:0]     slot_reg;
    logic [UW-1:0]     lim_reg;
    logic [SEC_W-1:0]  new_sec_reg;
    logic              grow_reg;
    logic              evict_reg;
    result_t           res1_reg;
    result_t           res2_reg;

    logic              we;
    logic [IW-1:0]     waddr;
    logic [EW-1:0]     wdata;
    logic [EW-1:0]     rdata;
    logic [PAGE_W-1:0] rd_page;
    logic [SEC_W-1:0]  rd_sec;
    logic [RW-1:0]     rd_rank;
    logic              issue;
    logic              full;
    logic              age;
    result_t           res_out;

    assign rd_page = rdata[EW-1 -: PAGE_W];
    assign rd_sec  = rdata[RW +: SEC_W];
    assign rd_rank = rdata[RW-1:0];
    assign issue   = (idx_reg < used_reg);
    assign full    = (used_reg == UW'(CACHE_LINES));
    assign age     = pend_reg && ({1'b0, rd_rank} < (RW+1)'(lim_reg));

    always_comb
    begin
        we    = 1'b0;
        waddr = pend_idx_reg;
        wdata = {rd_page, rd_sec, RW'(rd_rank + RW'(1))};
        if (state_reg == ST_TOUCH && age)
        begin
            we = 1'b1;
        end
        else if (state_reg == ST_COMMIT)
        begin
            we    = 1'b1;
            waddr = slot_reg;
            wdata = {page_reg, new_sec_reg, RW'(0)};
        end
    end

    lswc_line_ram
    #(
        .DEPTH (CACHE_LINES),
        .WIDTH (EW)
    )
    u_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata)
    );

    function automatic logic [SLOT_W-1:0] slot_out(input logic [IW-1:0] s);
        logic [SLOT_W+IW-1:0] t;
        t = {{SLOT_W{1'b0}}, s};
        return t[SLOT_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg       <= op_t'(s_axis_tuser);
                        page_reg     <= s_axis_tdata[ADDR_W-1:OFF_W];
                        rng_reg      <= range_mask(s_axis_tdata[OFF_W-1:0],
                                                   s_axis_tdata[ADDR_W +: LEN_W]);
                        idx_reg      <= '0;
                        pend_reg     <= 1'b0;
                        hit_reg      <= 1'b0;
                        lru_idx_reg  <= '0;
                        lru_rank_reg <= '0;
                        state_reg    <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    pend_reg     <= issue;
                    pend_idx_reg <= idx_reg[IW-1:0];
                    if (issue)
                    begin
                        idx_reg <= idx_reg + UW'(1);
                    end
                    if (pend_reg)
                    begin
                        if (!hit_reg && rd_page == page_reg)
                        begin
                            hit_reg      <= 1'b1;
                            hit_idx_reg  <= pend_idx_reg;
                            hit_sec_reg  <= rd_sec;
                            hit_rank_reg <= rd_rank;
                        end
                        if (rd_rank >= lru_rank_reg)
                        begin
                            lru_idx_reg  <= pend_idx_reg;
                            lru_rank_reg <= rd_rank;
                            lru_page_reg <= rd_page;
                            lru_sec_reg  <= rd_sec;
                        end
                    end
                    if (!issue && !pend_reg)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    idx_reg  <= '0;
                    pend_reg <= 1'b0;
                    if (op_reg == OP_READ)
                    begin
                        res2_reg.page_address <= page_reg;
                        res2_reg.last         <= 1'b1;
                        if (hit_reg)
                        begin
                            res2_reg.storage_bitmap <= rng_reg & ~hit_sec_reg;
                            res2_reg.cached_bitmap  <= rng_reg & hit_sec_reg;
                            res2_reg.slot_valid     <= 1'b1;
                            res2_reg.slot_id        <= slot_out(hit_idx_reg);
                            if ((rng_reg & hit_sec_reg) == '0)
                            begin
                                res2_reg.command <= CMD_READ_STORAGE;
                            end
                            else if ((rng_reg & ~hit_sec_reg) == '0)
                            begin
                                res2_reg.command <= CMD_READ_DRAM;
                            end
                            else
                            begin
                                res2_reg.command <= CMD_READ_BOTH;
                            end
                        end
                        else
                        begin
                            res2_reg.command        <= CMD_READ_STORAGE;
                            res2_reg.storage_bitmap <= FULL_MASK;
                            res2_reg.slot_valid     <= 1'b0;
                            res2_reg.slot_id        <= '0;
                            res2_reg.cached_bitmap  <= '0;
                        end
                        state_reg <= ST_EMIT2;
                    end
                    else
                    begin
                        if (hit_reg)
                        begin
                            slot_reg    <= hit_idx_reg;
                            lim_reg     <= UW'(hit_rank_reg);
                            new_sec_reg <= hit_sec_reg | rng_reg;
                            grow_reg    <= 1'b0;
                            evict_reg   <= 1'b0;
                        end
                        else if (!full)
                        begin
                            slot_reg    <= used_reg[IW-1:0];
                            lim_reg     <= used_reg;
                            new_sec_reg <= rng_reg;
                            grow_reg    <= 1'b1;
                            evict_reg   <= 1'b0;
                        end
                        else
                        begin
                            slot_reg    <= lru_idx_reg;
                            lim_reg     <= UW'(lru_rank_reg);
                            new_sec_reg <= rng_reg;
                            grow_reg    <= 1'b0;
                            evict_reg   <= 1'b1;
                            res1_reg.command        <= (lru_sec_reg == FULL_MASK) ?
                                                       CMD_WRITE_STORAGE :
                                                       CMD_UPDATE_STORAGE;
                            res1_reg.page_address   <= lru_page_reg;
                            res1_reg.storage_bitmap <= FULL_MASK & ~lru_sec_reg;
                            res1_reg.slot_valid     <= 1'b1;
                            res1_reg.slot_id        <= slot_out(lru_idx_reg);
                            res1_reg.cached_bitmap  <= lru_sec_reg;
                            res1_reg.last           <= 1'b0;
                        end
                        state_reg <= ST_TOUCH;
                    end
                end
                ST_TOUCH:
                begin
                    // age every line more recent than the touched one
                    pend_reg     <= issue;
                    pend_idx_reg <= idx_reg[IW-1:0];
                    if (issue)
                    begin
                        idx_reg <= idx_reg + UW'(1);
                    end
                    if (!issue && !pend_reg)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    if (grow_reg)
                    begin
                        used_reg <= used_reg + UW'(1);
                    end
                    res2_reg.command        <= CMD_WRITE_DRAM;
                    res2_reg.page_address   <= page_reg;
                    res2_reg.storage_bitmap <= '0;
                    res2_reg.slot_valid     <= 1'b1;
                    res2_reg.slot_id        <= slot_out(slot_reg);
                    res2_reg.cached_bitmap  <= new_sec_reg;
                    res2_reg.last           <= 1'b1;
                    state_reg <= evict_reg ? ST_EMIT1 : ST_EMIT2;
                end
                ST_EMIT1:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_EMIT2;
                    end
                end
                ST_EMIT2:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_out       = (state_reg == ST_EMIT1) ? res1_reg : res2_reg;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT1) || (state_reg == ST_EMIT2);
    assign m_axis_tuser  = res_out.command;
    assign m_axis_tlast  = res_out.last;
    assign m_axis_tdata  = {4'b0000, res_out.cached_bitmap, res_out.slot_id,
                            res_out.slot_valid, res_out.storage_bitmap,
                            res_out.page_address};

endmodule

// ===== test/lru_sector_write_cache_test.sv =====
// Self-checking stream testbench for the LRU sector write cache.
module lru_sector_write_cache_test
    import lswc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES     = 64;
    localparam int POOL_SIZE = 72;
    localparam int RAND_REQS = 1500;

    typedef struct
    {
        op_t              op;
        logic [31:0]      addr;
        logic [LEN_W-1:0] len;
    } request_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic m_axis_tlast;

    request_t pending_reqs[$];
    result_t  expected_cmds[$];

    // Own copy of the cache state
    logic [PAGE_W-1:0] tag_of[LINES];
    logic [SEC_W-1:0]  sectors_of[LINES];
    int unsigned       rank_of[LINES];
    int unsigned       lines_used;

    logic [PAGE_W-1:0] page_pool[POOL_SIZE];
    logic word_taken;
    int unsigned gap_left, burst_left, stall_left;
    bit failed;

    lru_sector_write_cache u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic promote(input int unsigned s, input int unsigned r);
        for (int unsigned i = 0; i < lines_used; i++)
        begin
            if (i != s && rank_of[i] < r)
                rank_of[i]++;
        end
        rank_of[s] = 0;
    endtask

    task automatic predict_commands(input request_t rq);
        logic [PAGE_W-1:0] page;
        logic [SEC_W-1:0]  covered;
        logic [SEC_W-1:0]  dram_part, storage_part;
        int                hit_slot;
        int unsigned       s, oldest;
        result_t           r;
        page     = rq.addr[31:3];
        covered  = '0;
        hit_slot = -1;
        for (int p = 0; p < SEC_W; p++)
        begin
            if (p >= int'(rq.addr[2:0]) && p < int'(rq.addr[2:0]) + int'(rq.len))
                covered[p] = 1'b1;
        end
        for (int unsigned i = 0; i < lines_used; i++)
        begin
            if (hit_slot < 0 && tag_of[i] == page)
                hit_slot = i;
        end
        if (rq.op == OP_WRITE)
        begin
            if (hit_slot >= 0)
            begin
                s = hit_slot;
                promote(s, rank_of[s]);
            end
            else
            begin
                if (lines_used < LINES)
                begin
                    s = lines_used;
                    promote(s, lines_used);
                    lines_used++;
                end
                else
                begin
                    oldest = 0;
                    for (int unsigned i = 0; i < LINES; i++)
                    begin
                        if (rank_of[i] >= rank_of[oldest])
                            oldest = i;
                    end
                    s = oldest;
                    r.command        = (sectors_of[s] == FULL_MASK) ? CMD_WRITE_STORAGE
                                                                    : CMD_UPDATE_STORAGE;
                    r.page_address   = tag_of[s];
                    r.storage_bitmap = FULL_MASK & ~sectors_of[s];
                    r.slot_valid     = 1'b1;
                    r.slot_id        = SLOT_W'(s);
                    r.cached_bitmap  = sectors_of[s];
                    r.last           = 1'b0;
                    expected_cmds.push_back(r);
                    promote(s, rank_of[s]);
                end
                tag_of[s]     = page;
                sectors_of[s] = '0;
            end
            sectors_of[s]    = sectors_of[s] | covered;
            r.command        = CMD_WRITE_DRAM;
            r.page_address   = tag_of[s];
            r.storage_bitmap = '0;
            r.slot_valid     = 1'b1;
            r.slot_id        = SLOT_W'(s);
            r.cached_bitmap  = sectors_of[s];
            r.last           = 1'b1;
        end
        else if (hit_slot < 0)
        begin
            r.command        = CMD_READ_STORAGE;
            r.page_address   = page;
            r.storage_bitmap = FULL_MASK;
            r.slot_valid     = 1'b0;
            r.slot_id        = '0;
            r.cached_bitmap  = '0;
            r.last           = 1'b1;
        end
        else
        begin
            dram_part        = covered & sectors_of[hit_slot];
            storage_part     = covered & ~sectors_of[hit_slot];
            r.command        = (dram_part == '0) ? CMD_READ_STORAGE :
                               (storage_part == '0) ? CMD_READ_DRAM : CMD_READ_BOTH;
            r.page_address   = tag_of[hit_slot];
            r.storage_bitmap = storage_part;
            r.slot_valid     = 1'b1;
            r.slot_id        = SLOT_W'(hit_slot);
            r.cached_bitmap  = dram_part;
            r.last           = 1'b1;
        end
        expected_cmds.push_back(r);
    endtask

    // Accept request words, predict, and check command words
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
        end
        else
        begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                predict_commands('{op: op_t'(s_axis_tuser), addr: s_axis_tdata[31:0],
                                   len: s_axis_tdata[35:32]});
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected word cmd=%0d tdata=%h last=%b", $time,
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (m_axis_tuser !== want.command || m_axis_tlast !== want.last
                        || m_axis_tdata[28:0] !== want.page_address
                        || m_axis_tdata[36:29] !== want.storage_bitmap
                        || m_axis_tdata[37] !== want.slot_valid
                        || m_axis_tdata[43:38] !== want.slot_id
                        || m_axis_tdata[51:44] !== want.cached_bitmap
                        || m_axis_tdata[55:52] !== 4'h0)
                    begin
                        $display({"%0t: mismatch expected cmd=%0d page=%h sbm=%h",
                                  " sv=%b slot=%0d cbm=%h last=%b"},
                                 $time, want.command, want.page_address,
                                 want.storage_bitmap, want.slot_valid, want.slot_id,
                                 want.cached_bitmap, want.last);
                        $display({"%0t:          actual   cmd=%0d page=%h sbm=%h",
                                  " sv=%b slot=%0d cbm=%h last=%b"},
                                 $time, m_axis_tuser, m_axis_tdata[28:0],
                                 m_axis_tdata[36:29], m_axis_tdata[37],
                                 m_axis_tdata[43:38], m_axis_tdata[51:44],
                                 m_axis_tlast);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Request driver: bursts with random gaps; hold a word until it is taken
    always @(negedge clk)
    begin
        request_t rq;
        if (rst_n)
        begin
            if (!s_axis_tvalid || word_taken)
            begin
                if (gap_left > 0 || pending_reqs.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    rq = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= rq.op;
                    s_axis_tdata  <= {4'h0, rq.len, rq.addr};
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // Command receiver: stall at random, with stall-free stretches
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 10);
        end
    end

    task automatic add_request(input op_t op, input logic [31:0] addr, input int len);
        pending_reqs.push_back('{op: op, addr: addr, len: LEN_W'(len)});
    endtask

    initial
    begin
        int k;
        logic [31:0] a;
        failed        = 1'b0;
        lines_used    = 0;
        gap_left      = 0;
        burst_left    = 4;
        stall_left    = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        for (int i = 0; i < LINES; i++)
        begin
            sectors_of[i] = '0;
            rank_of[i]    = 0;
        end
        page_pool[0] = '0;
        page_pool[1] = {PAGE_W{1'b1}};
        for (int i = 2; i < POOL_SIZE; i++)
            page_pool[i] = PAGE_W'($urandom);

        // Directed opening
        add_request(OP_READ,  32'h0000_0000, 8);   // read miss
        add_request(OP_WRITE, 32'h0000_0000, 8);   // fill, full line
        add_request(OP_READ,  32'h0000_0000, 8);   // read all from dram
        add_request(OP_READ,  32'h0000_0003, 0);   // zero length on a hit
        add_request(OP_WRITE, 32'hFFFF_FFFF, 8);   // last sector, range past line end
        add_request(OP_READ,  32'hFFFF_FFF8, 8);   // split dram and storage
        add_request(OP_READ,  32'hFFFF_FFF8, 7);   // storage only
        add_request(OP_WRITE, 32'hFFFF_FFFA, 3);
        add_request(OP_READ,  32'hFFFF_FFFB, 5);
        add_request(OP_WRITE, 32'h0000_0005, 0);   // write hit, nothing new
        add_request(OP_WRITE, 32'h1234_5671, 0);   // write miss, empty line
        add_request(OP_READ,  32'h1234_5670, 8);
        add_request(OP_READ,  32'h8765_4321, 4);
        for (int i = 0; i < 70; i++)                // overflow into evictions
            add_request(OP_WRITE, {PAGE_W'(i + 16), 3'(i)}, i % 9);
        add_request(OP_READ,  32'h0000_0000, 8);   // page evicted
        add_request(OP_WRITE, 32'h0000_0080, 8);

        // Random part, mostly on a page pool a little larger than the cache
        for (int i = 0; i < RAND_REQS; i++)
        begin
            k = $urandom_range(0, POOL_SIZE - 1);
            a = ($urandom_range(0, 9) == 0) ? $urandom
                                             : {page_pool[k], 3'($urandom_range(0, 7))};
            add_request(($urandom_range(0, 9) < 6) ? OP_WRITE : OP_READ, a,
                        $urandom_range(0, 8));
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (!failed && expected_cmds.size() == 0)
            $display("lru_sector_write_cache verification clean");
        else
            $display("lru_sector_write_cache verification failed");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("lru_sector_write_cache verification failed");
        $finish;
    end

endmodule

// ===== lru_sector_write_cache.f =====
rtl/lswc_pkg.sv
rtl/lswc_line_ram.sv
rtl/lru_sector_write_cache.sv
test/lru_sector_write_cache_test.sv
